// ===== rtl/assert_macros.svh =====
// Assertion macros used by the transmit back module of the frame checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk with arst_n held as disable.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk with arst_n held as disable.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lsfc_pkg.sv =====
// Types, codes and helper functions of the LIN slave frame checker.
`default_nettype none
package lsfc_pkg;

	// Status codes of a report
	localparam logic [1:0] ST_HDR_ERR = 2'd0;
	localparam logic [1:0] ST_GOOD    = 2'd1;
	localparam logic [1:0] ST_RESP    = 2'd2;

	// Kind codes of an output beat
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_TX     = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] REG_NODE_ID   = 2'd0;
	localparam logic [1:0] REG_RX_LEN    = 2'd1;
	localparam logic [1:0] REG_RESP_LEN  = 2'd2;
	localparam logic [1:0] REG_RESP_DATA = 2'd3;

	// Header byte values
	localparam logic [7:0] BREAK_BYTE = 8'h00;
	localparam logic [7:0] SYNC_BYTE  = 8'h55;

	// Depth of the report queue between front and back
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [5:0]  node_id;
		logic [3:0]  rx_len;
		logic [3:0]  resp_len;
		logic [63:0] resp_data;
	} cfg_t;

	// Protected identifier: parity bits P0 and P1 on top of the id
	function automatic logic [7:0] protected_id(input logic [5:0] id);
		logic p0;
		logic p1;
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		if (id == 6'h3F) begin
			return 8'hFF;
		end
		return {p1, p0, id};
	endfunction

	// Byte add with end-around carry
	function automatic logic [7:0] carry_add(input logic [7:0] sum, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, sum} + {1'b0, b};
		return s[8] ? (s[7:0] + 8'd1) : s[7:0];
	endfunction

	// Saturate a length register to the maximum byte count
	function automatic logic [3:0] clamp_len(input logic [3:0] v, input logic [3:0] max_len);
		return (v > max_len) ? max_len : v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/lin_slave_frame_checker.sv =====
// LIN slave frame checker: config registers, receive front, report queue, transmit back.
// Input: one byte per cycle; s_tready drops only while the report queue is full.
// A burst's report is queued as its last byte is taken; the queue holds up to four.
// Output: one beat per cycle while m_tready is high; a report is 1 beat, or on status 2 the
// response length (clamped to MAX_DATA_BYTES) + 2, paced by the single back-end sequencer.
// Reset (arst_n low, asynchronous): registers to their defaults, burst state, queue and back.
`default_nettype none
module lin_slave_frame_checker #(
	parameter int MAX_DATA_BYTES  = 8,
	parameter int RX_BUFFER_BYTES = 20
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic        s_tlast,   // burst_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [1:0] status, [9:2] tx_byte, rest zero
	output logic             m_tuser,   // [0] kind
	output logic             m_tlast,   // last
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_wdata
);
	import lsfc_pkg::*;

	cfg_t       cfg_q;
	logic       s_fire;
	logic       push;
	logic [1:0] push_status;
	logic       pop;
	logic [1:0] q_status;
	logic       q_full;
	logic       q_empty;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_id   <= 6'd52;
			cfg_q.rx_len    <= 4'd8;
			cfg_q.resp_len  <= 4'd8;
			cfg_q.resp_data <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NODE_ID:   cfg_q.node_id   <= cfg_wdata[5:0];
				REG_RX_LEN:    cfg_q.rx_len    <= cfg_wdata[3:0];
				REG_RESP_LEN:  cfg_q.resp_len  <= cfg_wdata[3:0];
				REG_RESP_DATA: cfg_q.resp_data <= cfg_wdata;
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	assign s_tready = !q_full;
	assign s_fire   = s_tvalid && s_tready;

	lsfc_front #(
		.MAX_DATA_BYTES (MAX_DATA_BYTES),
		.RX_BUFFER_BYTES(RX_BUFFER_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.s_fire     (s_fire),
		.rx_byte    (s_tdata),
		.burst_end  (s_tlast),
		.push       (push),
		.push_status(push_status)
	);

	lsfc_fifo #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(2)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (push_status),
		.pop   (pop),
		.rdata (q_status),
		.full  (q_full),
		.empty (q_empty)
	);

	lsfc_back #(
		.MAX_DATA_BYTES(MAX_DATA_BYTES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_status(q_status),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule
`default_nettype wire

// ===== rtl/lsfc_fifo.sv =====
// Short report queue between the receive front and the transmit back.
`default_nettype none
module lsfc_fifo #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;

	assign full  = (count_q == (AW + 1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lsfc_front.sv =====
// Receive front: checks header, sums data bytes and classifies each burst.
`default_nettype none
module lsfc_front #(
	parameter int MAX_DATA_BYTES  = 8,
	parameter int RX_BUFFER_BYTES = 20
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lsfc_pkg::cfg_t cfg,
	input  wire logic          s_fire,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          burst_end,
	output logic               push,
	output logic [1:0]         push_status
);
	import lsfc_pkg::*;

	localparam int POS_W = $clog2(RX_BUFFER_BYTES + 1);

	logic [POS_W-1:0] pos_q;
	logic             hdr_good_q;
	logic [7:0]       sum_q;
	logic [7:0]       rcv_q;
	logic             seen_q;

	logic [POS_W-1:0] pos_n;
	logic             hdr_good_n;
	logic [7:0]       sum_n;
	logic [7:0]       rcv_n;
	logic             seen_n;
	logic [7:0]       pid;
	logic [3:0]       dlen;
	logic [POS_W-1:0] data_end;

	assign pid      = protected_id(cfg.node_id);
	assign dlen     = clamp_len(cfg.rx_len, 4'(MAX_DATA_BYTES));
	assign data_end = POS_W'(3) + POS_W'(dlen);

	// Update burst state for the incoming byte
	always_comb begin
		pos_n      = pos_q;
		hdr_good_n = hdr_good_q;
		sum_n      = sum_q;
		rcv_n      = rcv_q;
		seen_n     = seen_q;
		if (pos_q < POS_W'(RX_BUFFER_BYTES)) begin
			if (pos_q == POS_W'(0)) begin
				if (rx_byte != BREAK_BYTE) hdr_good_n = 1'b0;
			end else if (pos_q == POS_W'(1)) begin
				if (rx_byte != SYNC_BYTE) hdr_good_n = 1'b0;
			end else if (pos_q == POS_W'(2)) begin
				if (rx_byte != pid) hdr_good_n = 1'b0;
				sum_n = pid;
			end else if (pos_q < data_end) begin
				sum_n = carry_add(sum_q, rx_byte);
			end else if (pos_q == data_end) begin
				rcv_n  = rx_byte;
				seen_n = 1'b1;
			end
			pos_n = pos_q + 1'b1;
		end
	end

	// Classify the burst on its final byte
	always_comb begin
		if (!hdr_good_n || (pos_n < POS_W'(3))) begin
			push_status = ST_HDR_ERR;
		end else if (seen_n && (rcv_n == ~sum_n)) begin
			push_status = ST_GOOD;
		end else begin
			push_status = ST_RESP;
		end
	end

	assign push = s_fire && burst_end;

	// Hold burst state; clear it after the report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			hdr_good_q <= 1'b1;
			sum_q      <= '0;
			rcv_q      <= '0;
			seen_q     <= 1'b0;
		end else if (s_fire) begin
			if (burst_end) begin
				pos_q      <= '0;
				hdr_good_q <= 1'b1;
				sum_q      <= '0;
				rcv_q      <= '0;
				seen_q     <= 1'b0;
			end else begin
				pos_q      <= pos_n;
				hdr_good_q <= hdr_good_n;
				sum_q      <= sum_n;
				rcv_q      <= rcv_n;
				seen_q     <= seen_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lsfc_back.sv =====
// Transmit back: plays out one report beat, then any response bytes and checksum.
`default_nettype none
`include "assert_macros.svh"
module lsfc_back #(
	parameter int MAX_DATA_BYTES = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lsfc_pkg::cfg_t cfg,
	input  wire logic           q_empty,
	input  wire logic [1:0]     q_status,
	output logic                pop,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [15:0]         m_tdata,  // [1:0] status, [9:2] tx_byte, rest zero
	output logic                m_tuser,  // [0] kind
	output logic                m_tlast
);
	import lsfc_pkg::*;

	localparam int IDX_W = $clog2(MAX_DATA_BYTES + 2);

	logic             busy_q;
	logic [1:0]       status_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       sum_q;

	logic [3:0]       rlen;
	logic [IDX_W-1:0] last_idx;
	logic [IDX_W+2:0] idx_m1;
	logic [2:0]       byte_sel;
	logic [7:0]       resp_byte;
	logic [7:0]       tx_byte;
	logic             final_beat;
	logic             m_fire;
	logic             load;

	assign rlen      = clamp_len(cfg.resp_len, 4'(MAX_DATA_BYTES));
	assign last_idx  = IDX_W'(rlen) + 1'b1;
	assign idx_m1    = {3'b000, idx_q} - 1'b1;
	assign byte_sel  = idx_m1[2:0];
	assign resp_byte = cfg.resp_data[{byte_sel, 3'b000} +: 8];

	// Final beat: the report alone, or the checksum after the response bytes
	assign final_beat = ((idx_q == '0) && (status_q != ST_RESP)) || (idx_q == last_idx);
	assign m_fire     = m_tvalid && m_tready;
	assign load       = !q_empty && (!busy_q || (m_fire && final_beat));
	assign pop        = load;

	// Select the beat payload
	always_comb begin
		if (idx_q == '0) begin
			tx_byte = 8'h00;
		end else if (idx_q == last_idx) begin
			tx_byte = ~sum_q;
		end else begin
			tx_byte = resp_byte;
		end
	end

	assign m_tvalid = busy_q;
	assign m_tuser  = (idx_q == '0) ? KIND_STATUS : KIND_TX;
	assign m_tdata  = {6'b000000, tx_byte, status_q};
	assign m_tlast  = final_beat;

	// Advance through the beats of a report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			status_q <= ST_HDR_ERR;
			idx_q    <= '0;
			sum_q    <= '0;
		end else if (load) begin
			busy_q   <= 1'b1;
			status_q <= q_status;
			idx_q    <= '0;
		end else if (m_fire) begin
			if (final_beat) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == '0) begin
					sum_q <= protected_id(cfg.node_id);
				end else begin
					sum_q <= carry_add(sum_q, resp_byte);
				end
			end
		end
	end

	`ASSERT_IMPL(a_pop_nonempty, pop, !q_empty, "pop from empty report queue")
	`ASSERT_NEXT(a_drain_idle, m_fire && final_beat && !load, !busy_q, "back busy after last beat")
	`ASSERT_NEXT(a_stall_hold, busy_q && !m_tready, $stable({idx_q, status_q}), "stalled beat moved")
	`ASSERT_IMPL(a_idx_range, busy_q, idx_q <= last_idx, "beat index past checksum")

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench of the LIN slave frame checker: directed and random bursts, scoreboard of reports.
`timescale 1ns / 1ps
module tb;
	import lsfc_pkg::*;

	localparam int MAX_LEN     = 8;
	localparam int RX_BUF      = 20;
	localparam int DRAIN_WAIT  = 4;
	localparam int STALL_LIMIT = 1000;

	// One output beat as the block should present it
	typedef struct {
		logic       kind;
		logic [1:0] status;
		logic [7:0] tx_byte;
		logic       fin;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
	logic        s_tlast = 1'b0;    // burst_end
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;           // [1:0] status, [9:2] tx_byte
	logic        m_tuser;           // [0] kind
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_NODE_ID;
	logic [63:0] cfg_wdata = 64'd0;

	// Register copies
	logic [5:0]  cur_node = 6'd52;
	logic [3:0]  cur_rx_len = 4'd8;
	logic [3:0]  cur_resp_len = 4'd8;
	logic [63:0] cur_resp_data = 64'd0;

	// Burst state copies
	int          pos = 0;
	logic        hdr_ok = 1'b1;
	logic [7:0]  frame_sum = 8'h00;
	logic [7:0]  got_csum = 8'h00;
	logic        csum_seen = 1'b0;

	beat_t       beats_due[$];
	logic [7:0]  frame_buf[$];
	int          err_cnt = 0;
	int          sent_cnt = 0;
	int          stall_cycles = 0;
	int          src_idle_pct = 32;
	int          snk_idle_pct = 48;

	lin_slave_frame_checker #(
		.MAX_DATA_BYTES(MAX_LEN),
		.RX_BUFFER_BYTES(RX_BUF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// Identifier with P0 in bit 6 and P1 in bit 7; id 63 maps to all ones
	function automatic logic [7:0] pid_of(input logic [5:0] id);
		if (&id) begin
			return 8'hFF;
		end
		return {~^{id[1], id[3], id[4], id[5]}, ^{id[0], id[1], id[2], id[4]}, id};
	endfunction

	// Add a byte and fold the carry back into bit 0
	function automatic logic [7:0] cadd(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[7:0] + {7'd0, t[8]};
	endfunction

	function automatic int sat_len(input logic [3:0] v);
		return (v > MAX_LEN) ? MAX_LEN : int'(v);
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR %0t: %s", $time, msg);
		err_cnt++;
	endtask

	task automatic expect_beat(input logic k, input logic [1:0] st, input logic [7:0] tx,
		input logic f);
		beat_t b;
		b.kind = k;
		b.status = st;
		b.tx_byte = tx;
		b.fin = f;
		beats_due.push_back(b);
	endtask

	// Track one accepted byte and queue the report and response it causes
	task automatic predict_reply(input logic [7:0] b, input logic fin);
		logic [7:0] pid;
		logic [7:0] rsum;
		logic [7:0] rb;
		logic [1:0] st;
		int dlen;
		pid = pid_of(cur_node);
		dlen = sat_len(cur_rx_len);
		if (pos < RX_BUF) begin
			if (pos == 0) begin
				if (b != BREAK_BYTE) hdr_ok = 1'b0;
			end else if (pos == 1) begin
				if (b != SYNC_BYTE) hdr_ok = 1'b0;
			end else if (pos == 2) begin
				if (b != pid) hdr_ok = 1'b0;
				frame_sum = pid;
			end else if (pos < 3 + dlen) begin
				frame_sum = cadd(frame_sum, b);
			end else if (pos == 3 + dlen) begin
				got_csum = b;
				csum_seen = 1'b1;
			end
			pos++;
		end
		if (fin) begin
			if (!hdr_ok || pos < 3) begin
				st = ST_HDR_ERR;
			end else if (csum_seen && got_csum == ~frame_sum) begin
				st = ST_GOOD;
			end else begin
				st = ST_RESP;
			end
			expect_beat(KIND_STATUS, st, 8'h00, st != ST_RESP);
			if (st == ST_RESP) begin
				rsum = pid;
				for (int i = 0; i < sat_len(cur_resp_len); i++) begin
					rb = cur_resp_data[8*i +: 8];
					rsum = cadd(rsum, rb);
					expect_beat(KIND_TX, ST_RESP, rb, 1'b0);
				end
				expect_beat(KIND_TX, ST_RESP, ~rsum, 1'b1);
			end
			pos = 0;
			hdr_ok = 1'b1;
			frame_sum = 8'h00;
			got_csum = 8'h00;
			csum_seen = 1'b0;
		end
	endtask

	// Offer one byte after a random gap and hold it until taken
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		predict_reply(b, fin);
		sent_cnt++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++) begin
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		end
	endtask

	// Drop valid, let every due beat arrive, then let the pipeline settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (beats_due.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_NODE_ID: cur_node = val[5:0];
			REG_RX_LEN: cur_rx_len = val[3:0];
			REG_RESP_LEN: cur_resp_len = val[3:0];
			default: cur_resp_data = val;
		endcase
	endtask

	// Fill the byte buffer with a well-formed frame for the current settings
	task automatic load_good_frame();
		logic [7:0] pid;
		logic [7:0] s;
		logic [7:0] d;
		pid = pid_of(cur_node);
		s = pid;
		frame_buf.delete();
		frame_buf.push_back(BREAK_BYTE);
		frame_buf.push_back(SYNC_BYTE);
		frame_buf.push_back(pid);
		for (int i = 0; i < sat_len(cur_rx_len); i++) begin
			d = 8'($urandom);
			s = cadd(s, d);
			frame_buf.push_back(d);
		end
		frame_buf.push_back(~s);
	endtask

	// Favor the extremes of a length register
	function automatic logic [63:0] pick_len();
		int r;
		r = $urandom_range(9);
		if (r == 0) return 64'd0;
		if (r == 1) return 64'd8;
		if (r == 2) return 64'd15;
		if (r == 3) return 64'($urandom_range(9, 15));
		return 64'($urandom_range(0, 8));
	endfunction

	task automatic shuffle_config();
		int r;
		wait_idle();
		if ($urandom_range(1)) begin
			r = $urandom_range(9);
			write_reg(REG_NODE_ID, (r == 0) ? 64'd63 : (r == 1) ? 64'd0 : 64'($urandom_range(63)));
		end
		if ($urandom_range(1)) write_reg(REG_RX_LEN, pick_len());
		if ($urandom_range(1)) write_reg(REG_RESP_LEN, pick_len());
		if ($urandom_range(1)) begin
			r = $urandom_range(9);
			write_reg(REG_RESP_DATA, (r == 0) ? 64'd0 : (r == 1) ? {64{1'b1}} :
				{32'($urandom), 32'($urandom)});
		end
	endtask

	// Mostly good frames, then damaged, cut, padded and noise bursts
	task automatic send_random_frame();
		int pick;
		int idx;
		pick = $urandom_range(99);
		load_good_frame();
		if (pick >= 93) begin
			frame_buf.delete();
			repeat ($urandom_range(1, 24)) frame_buf.push_back(8'($urandom));
		end else if (pick >= 85) begin
			repeat ($urandom_range(1, 18)) frame_buf.push_back(8'($urandom));
		end else if (pick >= 75) begin
			repeat ($urandom_range(1, frame_buf.size() - 1)) void'(frame_buf.pop_back());
		end else if (pick >= 67) begin
			idx = $urandom_range(2);
			frame_buf[idx] = frame_buf[idx] ^ 8'(1 << $urandom_range(7));
		end else if (pick >= 55) begin
			idx = $urandom_range(3, frame_buf.size() - 1);
			frame_buf[idx] = frame_buf[idx] ^ 8'(1 << $urandom_range(7));
		end
		send_frame();
	endtask

	// Header-only burst under the reset settings: status 2 and eight zero bytes
	task automatic test_reset_config();
		send_byte(BREAK_BYTE, 1'b0);
		send_byte(SYNC_BYTE, 1'b0);
		send_byte(pid_of(cur_node), 1'b1);
	endtask

	// Short headers and a fault in each header byte
	task automatic test_header_faults();
		send_byte(BREAK_BYTE, 1'b1);
		send_byte(BREAK_BYTE, 1'b0);
		send_byte(SYNC_BYTE, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(SYNC_BYTE, 1'b0);
		send_byte(pid_of(cur_node), 1'b1);
		send_byte(BREAK_BYTE, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(pid_of(cur_node), 1'b1);
		send_byte(BREAK_BYTE, 1'b0);
		send_byte(SYNC_BYTE, 1'b0);
		send_byte(pid_of(cur_node) ^ 8'h80, 1'b1);
	endtask

	// Id 63, no data bytes, saturated response of all ones
	task automatic test_id_extremes();
		wait_idle();
		write_reg(REG_NODE_ID, 64'd63);
		write_reg(REG_RX_LEN, 64'd0);
		write_reg(REG_RESP_LEN, 64'd15);
		write_reg(REG_RESP_DATA, {64{1'b1}});
		send_byte(BREAK_BYTE, 1'b0);
		send_byte(SYNC_BYTE, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(BREAK_BYTE, 1'b0);
		send_byte(SYNC_BYTE, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	// Change the data length between the header and the body of one burst
	task automatic test_config_mid_burst();
		logic [7:0] pid;
		wait_idle();
		write_reg(REG_NODE_ID, 64'd0);
		pid = pid_of(cur_node);
		send_byte(BREAK_BYTE, 1'b0);
		send_byte(SYNC_BYTE, 1'b0);
		send_byte(pid, 1'b0);
		wait_idle();
		write_reg(REG_RX_LEN, 64'd1);
		send_byte(8'h5A, 1'b0);
		send_byte(~cadd(pid, 8'h5A), 1'b1);
	endtask

	task automatic test_random_frames(input int src_pct, input int snk_pct, input int n_items);
		int start;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		start = sent_cnt;
		while (sent_cnt - start < n_items) begin
			if ($urandom_range(4) == 0) shuffle_config();
			send_random_frame();
		end
	endtask

	// Compare each output beat with the oldest expectation; stall the receiver at random
	always @(posedge clk) begin : beat_check
		beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (beats_due.size() == 0) begin
				report_error($sformatf("unexpected beat tdata=%h tuser=%b tlast=%b",
					m_tdata, m_tuser, m_tlast));
			end else begin
				want = beats_due.pop_front();
				if (m_tuser !== want.kind)
					report_error($sformatf("kind %b, expected %b", m_tuser, want.kind));
				if (m_tdata[1:0] !== want.status)
					report_error($sformatf("status %0d, expected %0d", m_tdata[1:0], want.status));
				if (m_tdata[9:2] !== want.tx_byte)
					report_error($sformatf("tx_byte %h, expected %h", m_tdata[9:2], want.tx_byte));
				if (m_tlast !== want.fin)
					report_error($sformatf("last %b, expected %b", m_tlast, want.fin));
			end
		end
		m_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// End the run when neither side moves a beat for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_header_faults();
		test_id_extremes();
		test_config_mid_burst();
		test_random_frames(32, 48, 76);
		test_random_frames(48, 32, 76);
		test_random_frames(0, 0, 76);
		wait_idle();
		repeat (16) @(posedge clk);
		if (beats_due.size() != 0)
			report_error($sformatf("%0d beats never arrived", beats_due.size()));
		if (err_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
